FILE: design/bedc_pkg.sv
package bedc_pkg;

	localparam int MAX_SWITCHES  = 8;
	localparam int SW_BITS       = 8;
	localparam int CNT_W         = 4;
	localparam int IN_TDATA_W    = 16;
	localparam int OUT_TDATA_W   = 24;
	localparam int OUT_USED_W    = 19;
	localparam int CFG_IDX_W     = 2;
	localparam int CFG_DATA_W    = 4;

	localparam logic [CNT_W-1:0] CNT_MAX = 4'd15;

	typedef enum logic [1:0] {
		OP_RECOUNT = 2'd0,
		OP_KICK    = 2'd1,
		OP_EMPTY   = 2'd2,
		OP_PROBE   = 2'd3
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SWITCH_COUNT  = 2'd0,
		REG_BASE_CAPACITY = 2'd1,
		REG_RETRY_LIMIT   = 2'd2,
		REG_TEST_MODE     = 2'd3
	} reg_idx_t;

	typedef enum logic [2:0] {
		ERR_NONE      = 3'd0,
		ERR_IDLE_LOST = 3'd1,
		ERR_KICK_FAIL = 3'd2,
		ERR_TOO_MANY  = 3'd3,
		ERR_COUNT_ROSE = 3'd4
	} err_t;

	// result fields, last member in the lowest bits
	typedef struct packed {
		logic             releasing;
		err_t             error_code;
		logic             recount_wanted;
		logic             pulse_solenoid;
		logic             went_full;
		logic             went_empty;
		logic             kick_succeeded;
		logic             kick_failed;
		logic             ball_entered;
		logic [CNT_W-1:0] pending_kicks;
		logic [CNT_W-1:0] ball_count;
	} result_t;

	// tdata bit positions of the result
	localparam int OB_COUNT_LO   = 0;
	localparam int OB_PEND_LO    = 4;
	localparam int OB_FAILED     = 9;
	localparam int OB_SUCCEEDED  = 10;
	localparam int OB_PULSE      = 13;
	localparam int OB_AGAIN      = 14;
	localparam int OB_ERR_LO     = 15;
	localparam int OB_RELEASING  = 18;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] a);
		logic [CNT_W:0] s;
		s = {1'b0, a} + {{CNT_W{1'b0}}, 1'b1};
		return s[CNT_W] ? CNT_MAX : s[CNT_W-1:0];
	endfunction

endpackage

FILE: design/ball_eject_device_controller.sv
// channel   | dir | transaction payload
// s_axis    | in  | tdata: op[1:0], switch_bits[9:2], locks_held[10]
// m_axis    | out | tdata: ball_count, pending_kicks, events, pulse, recount, error, releasing
// cfg       | in  | cfg_we / cfg_index / cfg_wdata, one register per cycle
//
// Input transaction to result: input register, then result register.
// One item per cycle sustained while m_axis_tready is high; the state update and result share the single compute step.
// arst_n clears state, registers to reset values and both valid flags.
// A stalled result holds while the next item waits in the input register.
module ball_eject_device_controller (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   s_axis_tvalid,
	output logic                                   s_axis_tready,
	// op[1:0], switch_bits[9:2], locks_held[10], zero fill
	input  logic [bedc_pkg::IN_TDATA_W-1:0]        s_axis_tdata,
	output logic                                   m_axis_tvalid,
	input  logic                                   m_axis_tready,
	// ball_count[3:0], pending_kicks[7:4], ball_entered[8], kick_failed[9],
	// kick_succeeded[10], went_empty[11], went_full[12], pulse_solenoid[13],
	// recount_wanted[14], error_code[17:15], releasing[18], zero fill
	output logic [bedc_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,
	input  logic                                   cfg_we,
	input  logic [bedc_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [bedc_pkg::CFG_DATA_W-1:0]        cfg_wdata
);

	localparam int W = bedc_pkg::CNT_W;

	// config registers
	logic [W-1:0] switch_count_q, base_capacity_q, retry_limit_q;
	logic         test_mode_q;

	// device state
	logic [W-1:0] count_now_q, count_before_q, capacity_q, kicks_q, retries_q;
	logic         release_q;

	// input stage
	logic                          valid_s1;
	bedc_pkg::op_t                 op_s1;
	logic [bedc_pkg::SW_BITS-1:0]  bits_s1;
	logic                          locks_s1;

	// result stage
	logic                valid_s2;
	bedc_pkg::result_t   res_s2;

	logic advance;
	assign advance       = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	// popcount of switches in use
	logic [W-1:0] sw_used;
	logic [W-1:0] pop;
	always_comb begin
		sw_used = (switch_count_q > W'(bedc_pkg::MAX_SWITCHES)) ?
			W'(bedc_pkg::MAX_SWITCHES) : switch_count_q;
		pop = '0;
		for (int i = 0; i < bedc_pkg::SW_BITS; i++) begin
			if (W'(i) < sw_used && bits_s1[i])
				pop = pop + W'(1);
		end
	end

	// next state and result
	logic [W-1:0]        cn, cb, ko, re, cap, can;
	logic                rm;
	logic [W:0]          cn_inc;
	bedc_pkg::result_t   res;
	always_comb begin
		cn  = count_now_q;
		cb  = count_before_q;
		ko  = kicks_q;
		re  = retries_q;
		cap = capacity_q;
		rm  = release_q;
		can = count_now_q - kicks_q;
		cn_inc = '0;
		res = '0;
		res.error_code = bedc_pkg::ERR_NONE;
		unique case (op_s1)
			bedc_pkg::OP_RECOUNT: begin
				cb = count_now_q;
				cn = pop;
				cn_inc = {1'b0, cn} + {{W{1'b0}}, 1'b1};
				if (!release_q) begin
					if (cn < cb) begin
						if (!test_mode_q)
							res.error_code = bedc_pkg::ERR_IDLE_LOST;
					end else if (cn > cb) begin
						res.ball_entered = 1'b1;
					end
				end else if (ko != '0) begin
					if (cn == cb) begin
						res.error_code = bedc_pkg::ERR_KICK_FAIL;
						res.kick_failed = 1'b1;
						re = bedc_pkg::sat_inc(re);
						if (re == retry_limit_q) begin
							ko = '0;
							rm = 1'b0;
						end
					end else if (cn < cb) begin
						if (cn_inc == {1'b0, cb}) begin
							res.kick_succeeded = 1'b1;
							ko = ko - W'(1);
							if (ko == '0)
								rm = 1'b0;
						end else begin
							res.error_code = bedc_pkg::ERR_TOO_MANY;
						end
					end else begin
						res.error_code = bedc_pkg::ERR_COUNT_ROSE;
					end
				end
				if (cn != cb) begin
					if (cn == '0) begin
						res.went_empty = 1'b1;
					end else if (cn > cap) begin
						res.went_full = 1'b1;
						ko = bedc_pkg::sat_inc(ko);
						re = '0;
					end
				end
				if (ko != '0 && cn != '0) begin
					res.recount_wanted = 1'b1;
					if (!locks_s1) begin
						rm = 1'b1;
						res.pulse_solenoid = 1'b1;
					end
				end
			end
			bedc_pkg::OP_KICK: begin
				if (count_now_q > kicks_q) begin
					ko = bedc_pkg::sat_inc(kicks_q);
					re = '0;
				end
				res.recount_wanted = 1'b1;
			end
			bedc_pkg::OP_EMPTY: begin
				if (count_now_q > kicks_q) begin
					ko = count_now_q;  // kicks + (count - kicks), never above 15
					re = '0;
					cap = (capacity_q > can) ? capacity_q - can : '0;
				end
				res.recount_wanted = 1'b1;
			end
			bedc_pkg::OP_PROBE: begin
				cn  = pop;
				cb  = pop;
				ko  = '0;
				re  = '0;
				cap = base_capacity_q;
				if (pop > base_capacity_q) begin
					ko = pop - base_capacity_q;
					res.recount_wanted = 1'b1;
				end
			end
			default: ;
		endcase
		res.ball_count    = cn;
		res.pending_kicks = ko;
		res.releasing     = rm;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			switch_count_q  <= 4'd1;
			base_capacity_q <= '0;
			retry_limit_q   <= 4'd5;
			test_mode_q     <= 1'b0;
			count_now_q     <= '0;
			count_before_q  <= '0;
			capacity_q      <= '0;
			kicks_q         <= '0;
			retries_q       <= '0;
			release_q       <= 1'b0;
			valid_s1        <= 1'b0;
			valid_s2        <= 1'b0;
		end else begin
			if (advance) begin
				count_now_q    <= cn;
				count_before_q <= cb;
				capacity_q     <= cap;
				kicks_q        <= ko;
				retries_q      <= re;
				release_q      <= rm;
			end
			if (cfg_we) begin
				unique case (bedc_pkg::reg_idx_t'(cfg_index))
					bedc_pkg::REG_SWITCH_COUNT:  switch_count_q <= cfg_wdata;
					bedc_pkg::REG_BASE_CAPACITY: begin
						base_capacity_q <= cfg_wdata;
						capacity_q      <= cfg_wdata;
					end
					bedc_pkg::REG_RETRY_LIMIT:   retry_limit_q <= cfg_wdata;
					bedc_pkg::REG_TEST_MODE:     test_mode_q <= cfg_wdata[0];
					default: ;
				endcase
			end
			if (s_axis_tready)
				valid_s1 <= s_axis_tvalid;
			if (advance)
				valid_s2 <= 1'b1;
			else if (m_axis_tready)
				valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			op_s1    <= bedc_pkg::op_t'(s_axis_tdata[1:0]);
			bits_s1  <= s_axis_tdata[9:2];
			locks_s1 <= s_axis_tdata[10];
		end
		if (advance)
			res_s2 <= res;
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {{(bedc_pkg::OUT_TDATA_W - bedc_pkg::OUT_USED_W){1'b0}}, res_s2};

endmodule

FILE: design/bedc_checker.sv
module bedc_checker (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 m_axis_tvalid,
	input logic                                 m_axis_tready,
	input logic [bedc_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);

	logic                          pulse, again, rel, failed, succeeded;
	logic [2:0]                    err;
	logic [bedc_pkg::CNT_W-1:0]    cnt;

	assign pulse     = m_axis_tdata[bedc_pkg::OB_PULSE];
	assign again     = m_axis_tdata[bedc_pkg::OB_AGAIN];
	assign rel       = m_axis_tdata[bedc_pkg::OB_RELEASING];
	assign failed    = m_axis_tdata[bedc_pkg::OB_FAILED];
	assign succeeded = m_axis_tdata[bedc_pkg::OB_SUCCEEDED];
	assign err       = m_axis_tdata[bedc_pkg::OB_ERR_LO +: 3];
	assign cnt       = m_axis_tdata[bedc_pkg::OB_COUNT_LO +: bedc_pkg::CNT_W];

	// coil fires only with a follow-up recount and in releasing state
	a_pulse_again: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && pulse |-> again && rel)
		else $error("pulse without recount or releasing");

	// a kick cannot both fail and succeed
	a_kick_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !(failed && succeeded))
		else $error("kick failed and succeeded together");

	// failed kick always carries its error code
	a_fail_err: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && failed |-> err == bedc_pkg::ERR_KICK_FAIL)
		else $error("kick failed without error code");

	// count never above the switch population
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> cnt <= bedc_pkg::CNT_W'(bedc_pkg::MAX_SWITCHES))
		else $error("ball count out of range");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled result changed");

endmodule

bind ball_eject_device_controller bedc_checker u_bedc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

FILE: test/testbench.sv
class eject_scoreboard;
	logic [3:0] sw_cfg, base_cap, retry_lim;
	logic       test_on;
	logic [3:0] balls_now, balls_prev, cap_now, kicks_owed, retries;
	logic       releasing;
	bedc_pkg::result_t pending[$];
	int errors, noted, checked;
	int n_succeeded, n_failed, n_pulses, n_full, n_cancelled;

	function new();
		sw_cfg = 4'd1;
		base_cap = 4'd0;
		retry_lim = 4'd5;
		test_on = 1'b0;
		balls_now = '0;
		balls_prev = '0;
		cap_now = '0;
		kicks_owed = '0;
		retries = '0;
		releasing = 1'b0;
	endfunction

	function void set_reg(bedc_pkg::reg_idx_t idx, logic [3:0] v);
		case (idx)
			bedc_pkg::REG_SWITCH_COUNT: sw_cfg = v;
			bedc_pkg::REG_BASE_CAPACITY: begin
				base_cap = v;
				cap_now = v;
			end
			bedc_pkg::REG_RETRY_LIMIT: retry_lim = v;
			default: test_on = v[0];
		endcase
	endfunction

	function logic [3:0] sat15(int s);
		return (s > 15) ? bedc_pkg::CNT_MAX : 4'(s);
	endfunction

	function logic [3:0] closed_switches(logic [7:0] bits);
		int used, c, i;
		used = int'(sw_cfg);
		if (used > bedc_pkg::MAX_SWITCHES) used = bedc_pkg::MAX_SWITCHES;
		if (used > bedc_pkg::SW_BITS) used = bedc_pkg::SW_BITS;
		c = 0;
		for (i = 0; i < used; i++)
			if (bits[i]) c++;
		return sat15(c);
	endfunction

	function bedc_pkg::result_t predict_status(bedc_pkg::op_t op, logic [7:0] bits,
			logic locks);
		bedc_pkg::result_t r;
		int can;
		r = '0;
		case (op)
			bedc_pkg::OP_RECOUNT: begin
				balls_prev = balls_now;
				balls_now = closed_switches(bits);
				if (!releasing) begin
					if (balls_now < balls_prev) begin
						if (!test_on) r.error_code = bedc_pkg::ERR_IDLE_LOST;
					end else if (balls_now > balls_prev) begin
						r.ball_entered = 1'b1;
					end
				end else if (kicks_owed != 0) begin
					if (balls_now == balls_prev) begin
						r.error_code = bedc_pkg::ERR_KICK_FAIL;
						r.kick_failed = 1'b1;
						retries = sat15(int'(retries) + 1);
						if (retries == retry_lim) begin
							kicks_owed = '0;
							releasing = 1'b0;
							n_cancelled++;
						end
					end else if (balls_now < balls_prev) begin
						if (int'(balls_now) + 1 == int'(balls_prev)) begin
							r.kick_succeeded = 1'b1;
							kicks_owed = kicks_owed - 4'd1;
							if (kicks_owed == 0) releasing = 1'b0;
						end else begin
							r.error_code = bedc_pkg::ERR_TOO_MANY;
						end
					end else begin
						r.error_code = bedc_pkg::ERR_COUNT_ROSE;
					end
				end
				if (balls_now != balls_prev) begin
					if (balls_now == 0) begin
						r.went_empty = 1'b1;
					end else if (balls_now > cap_now) begin
						r.went_full = 1'b1;
						kicks_owed = sat15(int'(kicks_owed) + 1);
						retries = '0;
					end
				end
				if (kicks_owed != 0 && balls_now != 0) begin
					r.recount_wanted = 1'b1;
					if (!locks) begin
						releasing = 1'b1;
						r.pulse_solenoid = 1'b1;
					end
				end
			end
			bedc_pkg::OP_KICK: begin
				if (balls_now > kicks_owed) begin
					kicks_owed = sat15(int'(kicks_owed) + 1);
					retries = '0;
				end
				r.recount_wanted = 1'b1;
			end
			bedc_pkg::OP_EMPTY: begin
				if (balls_now > kicks_owed) begin
					can = int'(balls_now) - int'(kicks_owed);
					kicks_owed = sat15(int'(kicks_owed) + can);
					retries = '0;
					cap_now = (int'(cap_now) > can) ? 4'(int'(cap_now) - can) : 4'd0;
				end
				r.recount_wanted = 1'b1;
			end
			default: begin
				// probe: resync, release state is kept
				balls_now = closed_switches(bits);
				balls_prev = balls_now;
				kicks_owed = '0;
				retries = '0;
				cap_now = base_cap;
				if (balls_now > cap_now) begin
					kicks_owed = balls_now - cap_now;
					r.recount_wanted = 1'b1;
				end
			end
		endcase
		r.ball_count = balls_now;
		r.pending_kicks = kicks_owed;
		r.releasing = releasing;
		return r;
	endfunction

	function void note_item(logic [bedc_pkg::IN_TDATA_W-1:0] tdata);
		pending.push_back(predict_status(bedc_pkg::op_t'(tdata[1:0]), tdata[9:2],
			tdata[10]));
		noted++;
	endfunction

	task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		errors++;
		$display("mismatch in %s: got %0h, wanted %0h at %0t", what, got, want, $time);
	endtask

	task check_field(string what, logic [7:0] got, logic [7:0] want);
		if (got !== want) report_mismatch(what, 32'(got), 32'(want));
	endtask

	task check_status(logic [bedc_pkg::OUT_TDATA_W-1:0] tdata);
		bedc_pkg::result_t got, want;
		got = tdata[bedc_pkg::OUT_USED_W-1:0];
		checked++;
		if (pending.size() == 0) begin
			report_mismatch("result with nothing outstanding", 32'(tdata), '0);
			return;
		end
		want = pending.pop_front();
		if (want.kick_succeeded) n_succeeded++;
		if (want.kick_failed) n_failed++;
		if (want.pulse_solenoid) n_pulses++;
		if (want.went_full) n_full++;
		check_field("ball_count", 8'(got.ball_count), 8'(want.ball_count));
		check_field("pending_kicks", 8'(got.pending_kicks), 8'(want.pending_kicks));
		check_field("ball_entered", 8'(got.ball_entered), 8'(want.ball_entered));
		check_field("kick_failed", 8'(got.kick_failed), 8'(want.kick_failed));
		check_field("kick_succeeded", 8'(got.kick_succeeded), 8'(want.kick_succeeded));
		check_field("went_empty", 8'(got.went_empty), 8'(want.went_empty));
		check_field("went_full", 8'(got.went_full), 8'(want.went_full));
		check_field("pulse_solenoid", 8'(got.pulse_solenoid), 8'(want.pulse_solenoid));
		check_field("recount_wanted", 8'(got.recount_wanted), 8'(want.recount_wanted));
		check_field("error_code", 8'(got.error_code), 8'(want.error_code));
		check_field("releasing", 8'(got.releasing), 8'(want.releasing));
		check_field("zero fill",
			8'(tdata[bedc_pkg::OUT_TDATA_W-1:bedc_pkg::OUT_USED_W]), '0);
	endtask
endclass

module testbench;
	localparam int STALL_LIMIT = 2000;

	typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    s_axis_tvalid = 1'b0;
	logic                    s_axis_tready;
	// op[1:0], switch_bits[9:2], locks_held[10], zero fill
	logic [bedc_pkg::IN_TDATA_W-1:0]   s_axis_tdata = '0;
	logic                    m_axis_tvalid;
	logic                    m_axis_tready = 1'b0;
	// ball_count[3:0], pending_kicks[7:4], ball_entered[8], kick_failed[9],
	// kick_succeeded[10], went_empty[11], went_full[12], pulse_solenoid[13],
	// recount_wanted[14], error_code[17:15], releasing[18], zero fill
	logic [bedc_pkg::OUT_TDATA_W-1:0]  m_axis_tdata;
	logic                    cfg_we = 1'b0;
	logic [bedc_pkg::CFG_IDX_W-1:0]    cfg_index = bedc_pkg::REG_SWITCH_COUNT;
	logic [bedc_pkg::CFG_DATA_W-1:0]   cfg_wdata = '0;

	eject_scoreboard sb;
	bit gaps_on = 1'b0;
	bit hold_request = 1'b0;
	int burst_left = 0;
	int balls = 0;
	int settings = 0;
	int stalled_cycles = 0;

	ball_eject_device_controller dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n && s_axis_tvalid && s_axis_tready) sb.note_item(s_axis_tdata);
		if (arst_n && m_axis_tvalid && m_axis_tready) sb.check_status(m_axis_tdata);
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			stalled_cycles = 0;
		else
			stalled_cycles++;
		if (stalled_cycles == STALL_LIMIT) begin
			$display("no transaction for %0d cycles", STALL_LIMIT);
			$display("== FAIL ==");
			$finish;
		end
	end

	// sink side: stall pattern changes every stretch; long hold on request
	initial begin
		rx_mode_t mode;
		int stretch, hold_left, cyc;
		mode = RX_OPEN;
		stretch = 0;
		hold_left = 0;
		cyc = 0;
		forever begin
			@(negedge clk);
			cyc++;
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left = 120;
			end
			if (stretch == 0) begin
				mode = rx_mode_t'($urandom_range(3, 0));
				stretch = $urandom_range(200, 20);
			end
			stretch--;
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				case (mode)
					RX_OPEN: m_axis_tready <= 1'b1;
					RX_COIN: m_axis_tready <= 1'($urandom_range(1, 0));
					RX_SPARSE: m_axis_tready <= ($urandom_range(3, 0) == 0);
					default: m_axis_tready <= (cyc % 7) < 4;
				endcase
			end
		end
	end

	task automatic send_item(bedc_pkg::op_t op, logic [7:0] bits, logic locks);
		int gap;
		@(negedge clk);
		if (burst_left == 0) begin
			burst_left = $urandom_range(24, 1);
			if (gaps_on) begin
				s_axis_tvalid <= 1'b0;
				gap = $urandom_range(6, 1);
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {5'b0, locks, bits, op};
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic write_reg(bedc_pkg::reg_idx_t idx, logic [3:0] v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= v;
		sb.set_reg(idx, v);
		@(negedge clk);
		cfg_we <= 1'b0;
		cfg_wdata <= 4'($urandom);
	endtask

	task automatic wait_idle();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (2) @(negedge clk);
	endtask

	task automatic configure(int sw, int cap, int rl, int tm);
		write_reg(bedc_pkg::REG_SWITCH_COUNT, 4'(sw));
		write_reg(bedc_pkg::REG_BASE_CAPACITY, 4'(cap));
		write_reg(bedc_pkg::REG_RETRY_LIMIT, 4'(rl));
		// upper data bits are don't-care for the one-bit register
		write_reg(bedc_pkg::REG_TEST_MODE, (4'($urandom) & 4'hE) | 4'(tm));
		settings++;
	endtask

	function automatic int ones_low(logic [7:0] bits, int n);
		int i, c;
		c = 0;
		for (i = 0; i < n; i++)
			if (bits[i]) c++;
		return c;
	endfunction

	// k closed switches among the n in use, unused switches random
	function automatic logic [7:0] mask_with(int k, int n);
		logic [7:0] m;
		int i, placed;
		m = 8'($urandom);
		for (i = 0; i < n; i++) m[i] = 1'b0;
		placed = 0;
		while (placed < k) begin
			i = $urandom_range(n - 1, 0);
			if (!m[i]) begin
				m[i] = 1'b1;
				placed++;
			end
		end
		return m;
	endfunction

	task automatic run_random(int n);
		int i, r, d, nsw;
		logic [7:0] bits;
		logic locks;
		bedc_pkg::op_t op;
		for (i = 0; i < n; i++) begin
			nsw = (sb.sw_cfg > 8) ? 8 : int'(sb.sw_cfg);
			if (balls > nsw) balls = nsw;
			r = $urandom_range(99, 0);
			locks = ($urandom_range(4, 0) == 0);
			bits = 8'($urandom);
			if (r < 72) begin
				op = bedc_pkg::OP_RECOUNT;
				if ($urandom_range(9, 0) < 8) begin
					// mechanical walk: mostly one ball in or out at a time
					d = $urandom_range(9, 0);
					if (d < 4 && balls > 0) balls--;
					else if (d > 6 && balls < nsw) balls++;
					bits = mask_with(balls, nsw);
				end else begin
					balls = ones_low(bits, nsw);
				end
			end else if (r < 82) begin
				op = bedc_pkg::OP_KICK;
			end else if (r < 88) begin
				op = bedc_pkg::OP_EMPTY;
			end else if (r < 95) begin
				op = bedc_pkg::OP_PROBE;
				bits = mask_with(balls, nsw);
			end else begin
				op = bedc_pkg::OP_RECOUNT;
				balls = ones_low(bits, nsw);
			end
			send_item(op, bits, locks);
		end
	endtask

	initial begin
		int p, sw, cap, rl, tm;
		sb = new();
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;

		configure(8, 2, 3, 0);
		send_item(bedc_pkg::OP_PROBE, 8'h00, 1'b0);
		send_item(bedc_pkg::OP_RECOUNT, 8'h01, 1'b0);
		send_item(bedc_pkg::OP_RECOUNT, 8'h07, 1'b0);
		send_item(bedc_pkg::OP_RECOUNT, 8'h07, 1'b0);
		send_item(bedc_pkg::OP_RECOUNT, 8'h03, 1'b0);
		send_item(bedc_pkg::OP_RECOUNT, 8'h00, 1'b0);
		send_item(bedc_pkg::OP_RECOUNT, 8'hFF, 1'b1);
		send_item(bedc_pkg::OP_KICK, 8'h5A, 1'b0);
		send_item(bedc_pkg::OP_EMPTY, 8'hA5, 1'b1);
		send_item(bedc_pkg::OP_RECOUNT, 8'hFF, 1'b0);
		send_item(bedc_pkg::OP_RECOUNT, 8'h0F, 1'b0);
		send_item(bedc_pkg::OP_RECOUNT, 8'hFF, 1'b0);
		send_item(bedc_pkg::OP_PROBE, 8'hFF, 1'b0);
		send_item(bedc_pkg::OP_PROBE, 8'h00, 1'b1);
		send_item(bedc_pkg::OP_KICK, 8'hFF, 1'b0);
		send_item(bedc_pkg::OP_EMPTY, 8'h00, 1'b0);
		send_item(bedc_pkg::OP_RECOUNT, 8'hAA, 1'b0);
		send_item(bedc_pkg::OP_RECOUNT, 8'h55, 1'b1);
		wait_idle();

		// retry limit zero never cancels; test mode hides idle losses
		configure(15, 0, 0, 1);
		send_item(bedc_pkg::OP_PROBE, 8'hFF, 1'b0);
		send_item(bedc_pkg::OP_RECOUNT, 8'hFF, 1'b0);
		send_item(bedc_pkg::OP_RECOUNT, 8'hFF, 1'b0);
		send_item(bedc_pkg::OP_RECOUNT, 8'h0F, 1'b0);
		send_item(bedc_pkg::OP_RECOUNT, 8'h3F, 1'b1);
		send_item(bedc_pkg::OP_RECOUNT, 8'h00, 1'b0);

		for (p = 0; p < 8; p++) begin
			wait_idle();
			case (p)
				0: begin sw = 8; cap = 0; rl = 1; tm = 0; end
				1: begin sw = 8; cap = 8; rl = 15; tm = 1; end
				2: begin sw = 0; cap = 0; rl = 5; tm = 0; end
				3: begin sw = 15; cap = 15; rl = 0; tm = 1; end
				4: begin sw = 4; cap = 2; rl = 3; tm = 0; end
				5: begin sw = 1; cap = 0; rl = 2; tm = 1; end
				default: begin
					sw = $urandom_range(15, 0);
					cap = $urandom_range(8, 0);
					rl = $urandom_range(15, 1);
					tm = $urandom_range(1, 0);
				end
			endcase
			configure(sw, cap, rl, tm);
			gaps_on = (p % 3) != 0;
			if (p == 0 || p == 4) hold_request = 1'b1;
			run_random((sw == 0) ? 60 : 230);
		end
		wait_idle();
		repeat (4) @(negedge clk);

		$display("%0d transactions in, %0d results checked, %0d register settings",
			sb.noted, sb.checked, settings);
		$display("kicks: %0d succeeded, %0d failed, %0d cancelled; %0d pulses, %0d full",
			sb.n_succeeded, sb.n_failed, sb.n_cancelled, sb.n_pulses, sb.n_full);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end
endmodule
